@@ rtl/ket_pkg.sv @@
// ============================================================================
// ket_pkg: shared types and constants for the keyed entry table
// Table sizing, operation and status codes, item payloads and the control
// structs passed between the key store and the sequencer.
// ============================================================================
`default_nettype none

package ket_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int AMOUNT_BITS = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // operation codes carried in the func field
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC,
        S_READ,
        S_MOVE,
        S_RESP
    } state_e;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  bet_name;
        logic [3:0]  pivot;
        logic        odds_flag;
        logic [31:0] amount;
    } req_item_t;

    typedef struct packed {
        status_e     status;
        logic [31:0] amount_out;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0] bet_name;
        logic [3:0] pivot;
        logic       odds_flag;
    } key_t;

    // key store write: either a new key or a copy of another slot's key
    typedef struct packed {
        logic             we;
        logic             move;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] src;
        key_t             key;
    } cam_cmd_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } cam_match_t;

endpackage

`default_nettype wire

@@ rtl/ket_ram.sv @@
// ============================================================================
// ket_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module ket_ram #(
    parameter  int DEPTH = 16,
    parameter  int WIDTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ket_cam.sv @@
// ============================================================================
// ket_cam: key store with parallel compare
// Holds one key per slot, compares all live slots against the search key
// and registers the hit flag and slot index.
// ============================================================================
`default_nettype none

module ket_cam (
    input  wire logic                     clk,
    input  wire ket_pkg::key_t            key,
    input  wire logic [ket_pkg::CNT_W-1:0] count,
    input  wire ket_pkg::cam_cmd_t        cmd,
    output ket_pkg::cam_match_t           match
);

    import ket_pkg::*;

    key_t                   keys_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [IDX_W-1:0]       hit_enc;

    // keys are unique, so OR-ing the indices of hits gives the single hit
    always_comb
    begin
        hit_enc = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_vec[i] = (CNT_W'(i) < count) && (keys_mem[i] == key);
            if (hit_vec[i])
            begin
                hit_enc = hit_enc | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            keys_mem[cmd.addr] <= cmd.move ? keys_mem[cmd.src] : cmd.key;
        end
        match.hit <= |hit_vec;
        match.idx <= hit_enc;
    end

endmodule

`default_nettype wire

@@ rtl/keyed_entry_table_top.sv @@
// Sequence: each item walks accept / compare / execute / RAM read-or-move /
//   respond; only a hit lookup or a delete that moves the last entry takes the
//   read-or-move step, and rsp_valid may also wait for the rsp register.
//   A new req is accepted only once the previous item is through (idle only).
// Reset: entry count and all handshake state cleared; the table is empty.
//   Key and amount storage keep no reset and are only read below the count.
// ============================================================================
// keyed_entry_table_top: associative key/amount table
// Keys live in a compare array, amounts in a synchronous RAM. A sequencer
// runs lookup, set/insert and delete (delete fills the hole with the last
// entry so the live entries stay packed at the low slots).
// ============================================================================
`default_nettype none

module keyed_entry_table_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire ket_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output ket_pkg::rsp_item_t      rsp
);

    import ket_pkg::*;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_e               state_reg, state_next;
    req_item_t            req_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg;
    status_e              status_reg, status_next;
    logic [31:0]          amt_res_reg;
    rsp_item_t            rsp_reg;
    logic                 rsp_valid_reg;

    // ------------------------------------------------------------------
    // key store and amount RAM
    // ------------------------------------------------------------------
    key_t                   search_key;
    cam_cmd_t               cam_cmd;
    cam_match_t             match;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [AMOUNT_BITS-1:0] ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [AMOUNT_BITS-1:0] ram_rdata;

    assign search_key = '{bet_name: req_reg.bet_name,
                          pivot: req_reg.pivot,
                          odds_flag: req_reg.odds_flag};

    ket_cam u_cam (
        .clk   (clk),
        .key   (search_key),
        .count (count_reg),
        .cmd   (cam_cmd),
        .match (match)
    );

    ket_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (AMOUNT_BITS)
    ) u_amt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // derived control
    // ------------------------------------------------------------------
    logic             table_full;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] tail_idx;
    logic             del_moves;
    logic             rsp_free;

    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign tail_idx   = IDX_W'(count_reg);
    // a delete of any slot but the last pulls the last entry into the hole
    assign del_moves  = match.hit && (match.idx != last_idx);
    assign rsp_free   = !rsp_valid_reg || rsp_ready;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                if (req_reg.func == OP_LOOKUP && match.hit)
                begin
                    state_next = S_READ;
                end
                else if (req_reg.func == OP_DELETE && del_moves)
                begin
                    state_next = S_MOVE;
                end
            end
            S_READ, S_MOVE:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        req_ready   = (state_reg == S_IDLE);
        cam_cmd     = '0;
        ram_we      = 1'b0;
        ram_waddr   = match.idx;
        ram_wdata   = AMOUNT_BITS'(req_reg.amount);
        ram_re      = 1'b0;
        ram_raddr   = match.idx;
        count_next  = count_reg;
        status_next = status_reg;

        unique case (state_reg)
            S_EXEC:
            begin
                status_next = ST_MISS;
                unique case (req_reg.func)
                    OP_LOOKUP:
                    begin
                        if (match.hit)
                        begin
                            ram_re      = 1'b1;
                            status_next = ST_OK;
                        end
                    end
                    OP_SET:
                    begin
                        if (match.hit)
                        begin
                            ram_we      = 1'b1;
                            status_next = ST_OK;
                        end
                        else if (!table_full)
                        begin
                            // append at the tail
                            ram_we      = 1'b1;
                            ram_waddr   = tail_idx;
                            cam_cmd.we  = 1'b1;
                            cam_cmd.addr = tail_idx;
                            cam_cmd.key = search_key;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (match.hit)
                        begin
                            count_next  = count_reg - CNT_W'(1);
                            status_next = ST_OK;
                            if (del_moves)
                            begin
                                cam_cmd.we   = 1'b1;
                                cam_cmd.move = 1'b1;
                                cam_cmd.addr = match.idx;
                                cam_cmd.src  = last_idx;
                                ram_re       = 1'b1;
                                ram_raddr    = last_idx;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_MISS;
                    end
                endcase
            end
            S_MOVE:
            begin
                // amount of the old last entry lands in the hole
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
            end
            S_IDLE, S_MATCH, S_READ, S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_RESP && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        status_reg <= status_next;
        if (state_reg == S_EXEC)
        begin
            idx_reg     <= match.idx;
            amt_res_reg <= '0;
        end
        if (state_reg == S_READ)
        begin
            amt_res_reg <= 32'(ram_rdata);
        end
        if (state_reg == S_RESP && rsp_free)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.amount_out <= amt_res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_EXEC))
        else $error("entry count changed outside execute");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second item taken while one is in flight");

    a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("amount RAM read and write hit the same slot");

endmodule

`default_nettype wire
